// File: rtl/utf8_stream_codec_assert.svh
// Assertion macros shared by the checker file of the UTF-8 stream codec.
`ifndef UTF8_STREAM_CODEC_ASSERT_SVH
`define UTF8_STREAM_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define USC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("usc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define USC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("usc assertion failed");

`endif

// File: rtl/usc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package usc_pkg;

    localparam int DATA_W  = 31;
    localparam int COUNT_W = 3;

    // Lead byte masks and patterns
    localparam logic [7:0] LEAD1_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_PAT  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_PAT  = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_PAT  = 8'hf0;
    localparam logic [7:0] LEAD5_MASK = 8'hfc;
    localparam logic [7:0] LEAD5_PAT  = 8'hf8;
    localparam logic [7:0] LEAD6_MASK = 8'hfe;
    localparam logic [7:0] LEAD6_PAT  = 8'hfc;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] CONT_KEEP  = 8'h3f;

    // Mode register codes
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;

    // Work item passed from the front to the back
    typedef struct packed {
        logic                 is_enc;  // encode: data is a code point to serialize
        logic [DATA_W-1:0]    data;    // decode result or code point
        logic [COUNT_W-1:0]   nbytes;  // encode: byte count, 1 to 6
        logic                 bad;     // decode: bad lead byte passed through
    } t_cmd;

    // Queue head as seen by the back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

`default_nettype wire

// File: rtl/usc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module usc_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_direction,
    input  wire                               i_valid,
    input  wire                               i_ready,
    input  wire  [usc_pkg::DATA_W-1:0]        i_data_in,
    output logic                              o_push,
    output usc_pkg::t_cmd                     o_cmd
);

    logic                         r_dir;
    logic [usc_pkg::COUNT_W-1:0]  r_pend, n_pend;
    logic [usc_pkg::DATA_W-1:0]   r_part, n_part;
    logic                         w_accept;
    logic [7:0]                   w_byte;
    logic [usc_pkg::COUNT_W-1:0]  w_len;

    assign w_accept = i_valid && i_ready;
    assign w_byte   = i_data_in[7:0];

    // Size the encoded form: shortest length for the code point
    always_comb begin
        if (i_data_in < 31'h80) begin
            w_len = 3'd1;
        end else if (i_data_in < 31'h800) begin
            w_len = 3'd2;
        end else if (i_data_in < 31'h10000) begin
            w_len = 3'd3;
        end else if (i_data_in < 31'h200000) begin
            w_len = 3'd4;
        end else if (i_data_in < 31'h4000000) begin
            w_len = 3'd5;
        end else begin
            w_len = 3'd6;
        end
    end

    // Classify the beat and advance the decode state
    always_comb begin
        n_pend = r_pend;
        n_part = r_part;
        o_push = 1'b0;
        o_cmd  = '0;
        if (w_accept && r_dir == usc_pkg::MODE_ENCODE) begin
            o_push       = 1'b1;
            o_cmd.is_enc = 1'b1;
            o_cmd.data   = i_data_in;
            o_cmd.nbytes = w_len;
        end else if (w_accept) begin
            if (r_pend != '0) begin
                // continuation: take low six bits, top bits unchecked
                n_part = {r_part[usc_pkg::DATA_W-7:0], w_byte[5:0]};
                n_pend = r_pend - 3'd1;
                if (r_pend == 3'd1) begin
                    o_push     = 1'b1;
                    o_cmd.data = n_part;
                end
            end else if ((w_byte & usc_pkg::LEAD1_MASK) == 8'h00) begin
                o_push     = 1'b1;
                o_cmd.data = {23'd0, w_byte};
            end else if ((w_byte & usc_pkg::LEAD2_MASK) == usc_pkg::LEAD2_PAT) begin
                n_part = {26'd0, w_byte[4:0]};
                n_pend = 3'd1;
            end else if ((w_byte & usc_pkg::LEAD3_MASK) == usc_pkg::LEAD3_PAT) begin
                n_part = {27'd0, w_byte[3:0]};
                n_pend = 3'd2;
            end else if ((w_byte & usc_pkg::LEAD4_MASK) == usc_pkg::LEAD4_PAT) begin
                n_part = {28'd0, w_byte[2:0]};
                n_pend = 3'd3;
            end else if ((w_byte & usc_pkg::LEAD5_MASK) == usc_pkg::LEAD5_PAT) begin
                n_part = {29'd0, w_byte[1:0]};
                n_pend = 3'd4;
            end else if ((w_byte & usc_pkg::LEAD6_MASK) == usc_pkg::LEAD6_PAT) begin
                n_part = {30'd0, w_byte[0]};
                n_pend = 3'd5;
            end else begin
                // bad lead: pass the byte through flagged
                o_push     = 1'b1;
                o_cmd.data = {23'd0, w_byte};
                o_cmd.bad  = 1'b1;
            end
        end
    end

    // Hold mode and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= usc_pkg::MODE_DECODE;
            r_pend <= '0;
            r_part <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dir <= i_cfg_direction;
            end
            r_pend <= n_pend;
            r_part <= n_part;
        end
    end

endmodule

`default_nettype wire

// File: rtl/usc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module usc_queue #(
    parameter int DEPTH = 2
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  usc_pkg::t_cmd       i_cmd,
    input  wire                 i_pop,
    output logic                o_full,
    output usc_pkg::t_head      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    usc_pkg::t_cmd  r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           w_pop;

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];
    assign w_pop        = i_pop && o_head.valid;

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if ((i_push && !o_full) && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!(i_push && !o_full) && w_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/usc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module usc_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  usc_pkg::t_head               i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [usc_pkg::DATA_W-1:0]   o_data_out,
    output logic                         o_last,
    output logic                         o_bad_lead
);

    logic                         r_valid;
    logic [usc_pkg::DATA_W-1:0]   r_data;
    logic                         r_last, r_bad;
    logic [usc_pkg::COUNT_W-1:0]  r_idx, n_idx;
    logic                         w_load;
    logic [usc_pkg::COUNT_W-1:0]  w_rem;
    logic [4:0]                   w_sh;
    logic [usc_pkg::DATA_W-1:0]   w_shifted;
    logic [7:0]                   w_keep, w_mark, w_byte;
    logic                         w_enc_last;
    logic [usc_pkg::DATA_W-1:0]   n_data;
    logic                         n_last, n_bad;

    assign w_load = i_head.valid && (!r_valid || i_ready);

    // Pick the six-bit group for the current byte
    assign w_rem      = i_head.cmd.nbytes - 3'd1 - r_idx;
    assign w_enc_last = (r_idx == i_head.cmd.nbytes - 3'd1);

    always_comb begin
        case (w_rem)
            3'd0:    w_sh = 5'd0;
            3'd1:    w_sh = 5'd6;
            3'd2:    w_sh = 5'd12;
            3'd3:    w_sh = 5'd18;
            3'd4:    w_sh = 5'd24;
            default: w_sh = 5'd30;
        endcase
    end

    assign w_shifted = i_head.cmd.data >> w_sh;

    // Lead byte mark and payload mask by sequence length
    always_comb begin
        case (i_head.cmd.nbytes)
            3'd1:    begin w_keep = 8'h7f; w_mark = 8'h00;             end
            3'd2:    begin w_keep = 8'h1f; w_mark = usc_pkg::LEAD2_PAT; end
            3'd3:    begin w_keep = 8'h0f; w_mark = usc_pkg::LEAD3_PAT; end
            3'd4:    begin w_keep = 8'h07; w_mark = usc_pkg::LEAD4_PAT; end
            3'd5:    begin w_keep = 8'h03; w_mark = usc_pkg::LEAD5_PAT; end
            default: begin w_keep = 8'h01; w_mark = usc_pkg::LEAD6_PAT; end
        endcase
    end

    always_comb begin
        if (r_idx == '0) begin
            w_byte = (w_shifted[7:0] & w_keep) | w_mark;
        end else begin
            w_byte = (w_shifted[7:0] & usc_pkg::CONT_KEEP) | usc_pkg::CONT_MARK;
        end
    end

    // Build the next beat and decide when the head is done
    always_comb begin
        n_idx = r_idx;
        o_pop = 1'b0;
        if (i_head.cmd.is_enc) begin
            n_data = {23'd0, w_byte};
            n_last = w_enc_last;
            n_bad  = 1'b0;
            if (w_load) begin
                o_pop = w_enc_last;
                n_idx = w_enc_last ? '0 : r_idx + 3'd1;
            end
        end else begin
            n_data = i_head.cmd.data;
            n_last = 1'b1;
            n_bad  = i_head.cmd.bad;
            o_pop  = w_load;
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
            r_last <= n_last;
            r_bad  <= n_bad;
        end
    end

    assign o_valid    = r_valid;
    assign o_data_out = r_data;
    assign o_last     = r_last;
    assign o_bad_lead = r_bad;

endmodule

`default_nettype wire

// File: rtl/utf8_stream_codec.sv
// UTF-8 stream codec, 31-bit code points, sequences of up to six bytes.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_direction): 0 decodes bytes
// to code points, 1 encodes code points to bytes. Write it only while idle.
// Input channel (i_valid / o_ready, i_data_in): decode takes one byte in bits
// 7..0; encode takes one code point.
// Output channel (o_valid / i_ready): o_data_out, o_last on the final beat of
// an item, o_bad_lead when a decode lead byte was invalid and passed raw.
// Path: the input beat completing an item is written into the queue, and the
// result beat is then loaded from the queue head into the output register.
// Throughput: decode takes one byte per cycle, encode emits one byte per cycle
// when not stalled, so a code point holds the serializer for its 1 to 6 bytes.
// The input side runs ahead into a QUEUE_DEPTH-entry queue and stalls only
// when it is full; a stalled receiver holds the output beat and then the queue.
// Reset clears mode to decode, drops any partial sequence and empties the
// queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire                          i_cfg_direction,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [usc_pkg::DATA_W-1:0]   i_data_in,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [usc_pkg::DATA_W-1:0]   o_data_out,
    output logic                         o_last,
    output logic                         o_bad_lead
);

    logic            w_push, w_pop, w_full;
    usc_pkg::t_cmd   w_cmd;
    usc_pkg::t_head  w_head;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !w_full;

    usc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_direction (i_cfg_direction),
        .i_valid         (i_valid),
        .i_ready         (o_ready),
        .i_data_in       (i_data_in),
        .o_push          (w_push),
        .o_cmd           (w_cmd)
    );

    usc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    usc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data_out (o_data_out),
        .o_last     (o_last),
        .o_bad_lead (o_bad_lead)
    );

endmodule

`default_nettype wire

// File: rtl/usc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_codec_assert.svh"

module usc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_ready,
    input wire  [usc_pkg::DATA_W-1:0]   o_data_out,
    input wire                          o_last,
    input wire                          o_bad_lead
);

    // stalled beat holds
    `USC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data_out) && $stable(o_last) && $stable(o_bad_lead))
    // bad lead is a single-beat item
    `USC_ASSERT_NOW(a_bad_last, i_clk, i_rst_n, o_valid && o_bad_lead, o_last)
    // bad lead carries only the raw byte
    `USC_ASSERT_NOW(a_bad_byte, i_clk, i_rst_n, o_valid && o_bad_lead, o_data_out[30:8] == 23'd0 && o_data_out[7:6] != 2'b00)
    // nothing shows right after reset
    `USC_ASSERT_NOW(a_rst_idle, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

endmodule

bind utf8_stream_codec usc_checker u_usc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_data_out (o_data_out),
    .o_last     (o_last),
    .o_bad_lead (o_bad_lead)
);

`default_nettype wire
